@@ rtl/tbpm_pkg.sv @@
package tbpm_pkg;

	// Fixed field widths
	localparam int unsigned STATUS_W  = 3;
	localparam int unsigned BUFIDX_W  = 6;
	localparam int unsigned DLEN_W    = 12;
	localparam int unsigned FCOUNT_W  = 7;
	localparam int unsigned CNT_W     = 32;
	localparam int unsigned FLEN_W    = 12;
	localparam int unsigned DESC_W    = 8;
	localparam int unsigned MAXLEN_W  = 11;
	localparam int unsigned APB_AW    = 3;
	localparam int unsigned APB_DW    = 32;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_INVALID    = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_QUEUE_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_IO_ERROR   = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NOT_READY  = 3'd4;

	// Item commands
	localparam logic CMD_SEND = 1'b0;
	localparam logic CMD_DONE = 1'b1;

	// Register select (paddr[2])
	localparam logic REG_DEVICE_READY = 1'b0;
	localparam logic REG_MAX_PKT_LEN  = 1'b1;

	localparam logic [MAXLEN_W-1:0] MAX_PKT_LEN_RST = 11'd1514;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} ctrl_state_t;

	typedef struct packed {
		logic clear;   // init sweep of both memories
		logic load;    // beat accepted: latch fields, read memories
		logic exec;    // resolve item, write back, post result
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_done;
	} dp_stat_t;

	typedef struct packed {
		logic                device_ready;
		logic [MAXLEN_W-1:0] max_pkt_len;
	} cfg_regs_t;

endpackage

@@ rtl/tbpm_ctrl.sv @@
module tbpm_ctrl
	import tbpm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output ctrl_cmd_t cmd,
	input  dp_stat_t  stat
);

	ctrl_state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign cmd.clear = (state_q == ST_CLEAR);
	assign cmd.load  = (state_q == ST_IDLE) && start;
	assign cmd.exec  = (state_q == ST_EXEC);

endmodule

@@ rtl/tbpm_datapath.sv @@
module tbpm_datapath
	import tbpm_pkg::*;
#(
	parameter int unsigned BUF_COUNT   = 64,
	parameter int unsigned QUEUE_DEPTH = 256,
	parameter int unsigned HDR_BYTES   = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_cmd_t           cmd,
	output dp_stat_t            stat,
	input  cfg_regs_t           cfg,
	input  logic                cmd_in,
	input  logic [FLEN_W-1:0]   pkt_len,
	input  logic [DESC_W-1:0]   desc_id,
	input  logic                ring_full,
	input  logic                copy_error,
	output logic                result_valid,
	output logic [STATUS_W-1:0] status,
	output logic [BUFIDX_W-1:0] buf_index,
	output logic [DLEN_W-1:0]   desc_length,
	output logic [FCOUNT_W-1:0] free_count,
	output logic [CNT_W-1:0]    sent_count,
	output logic [CNT_W-1:0]    done_count
);

	localparam int unsigned BW        = $clog2(BUF_COUNT);
	localparam int unsigned QW        = $clog2(QUEUE_DEPTH);
	localparam int unsigned CLR_DEPTH = (BUF_COUNT > QUEUE_DEPTH) ? BUF_COUNT : QUEUE_DEPTH;
	localparam int unsigned CW        = $clog2(CLR_DEPTH);

	// Memories
	logic [BW-1:0] free_stack [BUF_COUNT];
	logic [BW-1:0] desc_map   [QUEUE_DEPTH];

	// Control state
	logic [CW-1:0] clr_cnt_q;
	logic [BW:0]   top_q;
	logic [CNT_W-1:0] sent_q, done_q;
	logic          res_valid_q;

	// Latched item and read data
	logic                cmd_q, rfull_q, cerr_q, in_range_q;
	logic [FLEN_W-1:0]   flen_q;
	logic [QW-1:0]       desc_idx_q;
	logic [BW-1:0]       rd_stack_q;
	logic [BW-1:0]       rd_map_q;

	// Result payload
	logic [STATUS_W-1:0] status_q;
	logic [BUFIDX_W-1:0] bidx_q;
	logic [DLEN_W-1:0]   dlen_q;

	logic [QW+DESC_W-1:0] desc_wide;
	logic [BW:0]          top_m1;
	logic [BW:0]          b_done;
	logic                 is_done, not_ready, len_bad, empty, popped, post, push_ok;
	logic [STATUS_W-1:0]  status_d;
	logic [BW:0]          bidx_d;
	logic [BW+BUFIDX_W:0] bidx_wide;
	logic [BW+FCOUNT_W:0] top_wide;
	logic [DLEN_W:0]      dlen_sum;
	logic                 fs_we, dm_we;
	logic [BW-1:0]        fs_addr, fs_data;
	logic [QW-1:0]        dm_addr;
	logic [BW-1:0]        dm_data;

	assign desc_wide = {{QW{1'b0}}, desc_id};
	assign top_m1    = top_q - 1'b1;

	assign stat.clear_done = (clr_cnt_q == CW'(CLR_DEPTH - 1));

	// Item resolution
	assign is_done   = (cmd_q == CMD_DONE);
	assign b_done    = in_range_q ? {1'b0, rd_map_q} : (BW+1)'(BUF_COUNT);
	assign push_ok   = (32'(b_done) < BUF_COUNT) && (32'(top_q) < BUF_COUNT);
	assign not_ready = !cfg.device_ready;
	assign len_bad   = (flen_q == '0) || (flen_q > {1'b0, cfg.max_pkt_len});
	assign empty     = (top_q == '0);
	assign popped    = !is_done && !not_ready && !len_bad && !empty;
	assign post      = popped && !cerr_q && !rfull_q;
	assign dlen_sum  = (DLEN_W+1)'(HDR_BYTES) + {1'b0, flen_q};

	always_comb begin
		if (is_done) begin
			status_d = STAT_OK;
		end else if (not_ready) begin
			status_d = STAT_NOT_READY;
		end else if (len_bad) begin
			status_d = STAT_INVALID;
		end else if (empty) begin
			status_d = STAT_QUEUE_FULL;
		end else if (cerr_q) begin
			status_d = STAT_IO_ERROR;
		end else if (rfull_q) begin
			status_d = STAT_QUEUE_FULL;
		end else begin
			status_d = STAT_OK;
		end
	end

	always_comb begin
		if (is_done) begin
			bidx_d = b_done;
		end else if (popped) begin
			bidx_d = {1'b0, rd_stack_q};
		end else begin
			bidx_d = '0;
		end
	end

	assign bidx_wide = {{BUFIDX_W{1'b0}}, bidx_d};
	assign top_wide  = {{FCOUNT_W{1'b0}}, top_q};

	// Write ports: init sweep or item write-back.
	// A rejected pop (copy error, full ring) would rewrite the same slot, so it is skipped.
	always_comb begin
		fs_we   = 1'b0;
		fs_addr = top_q[BW-1:0];
		fs_data = b_done[BW-1:0];
		dm_we   = 1'b0;
		dm_addr = desc_idx_q;
		dm_data = rd_stack_q;
		if (cmd.clear) begin
			fs_we   = (32'(clr_cnt_q) < BUF_COUNT);
			fs_addr = clr_cnt_q[BW-1:0];
			fs_data = clr_cnt_q[BW-1:0];
			dm_we   = (32'(clr_cnt_q) < QUEUE_DEPTH);
			dm_addr = clr_cnt_q[QW-1:0];
			dm_data = '0;
		end else if (cmd.exec) begin
			fs_we = is_done && push_ok;
			dm_we = post && in_range_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fs_we) begin
			free_stack[fs_addr] <= fs_data;
		end
		if (dm_we) begin
			desc_map[dm_addr] <= dm_data;
		end
		if (cmd.load) begin
			rd_stack_q <= free_stack[top_m1[BW-1:0]];
			rd_map_q   <= desc_map[desc_wide[QW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q      <= cmd_in;
			flen_q     <= pkt_len;
			desc_idx_q <= desc_wide[QW-1:0];
			in_range_q <= (32'(desc_id) < QUEUE_DEPTH);
			rfull_q    <= ring_full;
			cerr_q     <= copy_error;
		end
		if (cmd.exec) begin
			status_q <= status_d;
			bidx_q   <= bidx_wide[BUFIDX_W-1:0];
			dlen_q   <= post ? dlen_sum[DLEN_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			top_q       <= (BW+1)'(BUF_COUNT);
			sent_q      <= '0;
			done_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.exec;
			if (cmd.clear && !stat.clear_done) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.exec) begin
				if (is_done) begin
					done_q <= done_q + 1'b1;
					if (push_ok) begin
						top_q <= top_q + 1'b1;
					end
				end else if (post) begin
					top_q  <= top_m1;
					sent_q <= sent_q + 1'b1;
				end
			end
		end
	end

	assign result_valid = res_valid_q;
	assign status       = status_q;
	assign buf_index    = bidx_q;
	assign desc_length  = dlen_q;
	assign free_count   = top_wide[FCOUNT_W-1:0];
	assign sent_count   = sent_q;
	assign done_count   = done_q;

endmodule

@@ rtl/tx_buffer_pool_manager_unit.sv @@
// Accept latches the item and reads memories; execute resolves it and registers result_valid.
// A new item waits until idle: busy is high for the one execute cycle after each accept.
// The per-item loop is set by the stack top: memory read at accept, resolve and write-back next.
// Reset: async, active low. After reset a sweep over max(BUF_COUNT, QUEUE_DEPTH) addresses
// initializes the free stack and descriptor map; busy stays high until it finishes.
// Results cannot be stalled: each is shown for exactly one cycle.
module tx_buffer_pool_manager_unit
	import tbpm_pkg::*;
#(
	parameter int unsigned BUF_COUNT   = 64,
	parameter int unsigned QUEUE_DEPTH = 256,
	parameter int unsigned HDR_BYTES   = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	// item beat
	input  logic                start,
	output logic                busy,
	input  logic                cmd,
	input  logic [FLEN_W-1:0]   pkt_len,
	input  logic [DESC_W-1:0]   desc_id,
	input  logic                ring_full,
	input  logic                copy_error,
	// config port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready,
	// result beat
	output logic                result_valid,
	output logic [STATUS_W-1:0] status,
	output logic [BUFIDX_W-1:0] buf_index,
	output logic [DLEN_W-1:0]   desc_length,
	output logic [FCOUNT_W-1:0] free_count,
	output logic [CNT_W-1:0]    sent_count,
	output logic [CNT_W-1:0]    done_count
);

	ctrl_cmd_t ctrl_cmd;
	dp_stat_t  dp_stat;
	cfg_regs_t cfg_q;
	logic      cfg_wr;

	// Config registers: device_ready at 0x0, max_pkt_len at 0x4. Only paddr[2] selects.
	// Software must write these only while the block is idle; the block does not enforce it.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_ready <= 1'b0;
			cfg_q.max_pkt_len  <= MAX_PKT_LEN_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_DEVICE_READY: begin
					cfg_q.device_ready <= pwdata[0];
				end
				REG_MAX_PKT_LEN: begin
					cfg_q.max_pkt_len <= pwdata[MAXLEN_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Read-back mux
	always_comb begin
		unique case (paddr[2])
			REG_DEVICE_READY: begin
				prdata = {{(APB_DW-1){1'b0}}, cfg_q.device_ready};
			end
			REG_MAX_PKT_LEN: begin
				prdata = {{(APB_DW-MAXLEN_W){1'b0}}, cfg_q.max_pkt_len};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// Sequencer: init sweep -> idle <-> execute
	tbpm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (ctrl_cmd),
		.stat   (dp_stat)
	);

	// Free stack, descriptor map, counters and result registers
	tbpm_datapath #(
		.BUF_COUNT   (BUF_COUNT),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.HDR_BYTES   (HDR_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (ctrl_cmd),
		.stat         (dp_stat),
		.cfg          (cfg_q),
		.cmd_in       (cmd),
		.pkt_len      (pkt_len),
		.desc_id      (desc_id),
		.ring_full    (ring_full),
		.copy_error   (copy_error),
		.result_valid (result_valid),
		.status       (status),
		.buf_index    (buf_index),
		.desc_length  (desc_length),
		.free_count   (free_count),
		.sent_count   (sent_count),
		.done_count   (done_count)
	);

endmodule

@@ rtl/tbpm_checker.sv @@
module tbpm_checker
	import tbpm_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                result_valid,
	input logic [STATUS_W-1:0] status,
	input logic [BUFIDX_W-1:0] buf_index,
	input logic [DLEN_W-1:0]   desc_length
);

	// Every accepted beat yields a result strobe once its execute state has run.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 result_valid)
		else $error("result strobe missing after accepted beat");

	// Execute always returns to idle before the next accept, so strobes never come back to back.
	a_no_double_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("back-to-back result strobes");

	// Only a posted send carries a descriptor length.
	a_reject_no_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != STAT_OK) |-> (desc_length == '0))
		else $error("rejected item reports a descriptor length");

	// Early rejection never names a buffer.
	a_not_ready_no_buf: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && ((status == STAT_NOT_READY) || (status == STAT_INVALID))
		|-> (buf_index == '0))
		else $error("early-rejected send reports a buffer");

endmodule

bind tx_buffer_pool_manager_unit tbpm_checker u_tbpm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.status       (status),
	.buf_index    (buf_index),
	.desc_length  (desc_length)
);
